[rtl/dqec_pkg.sv]
// Shared types, constants and the step lookup for the dual quadrature encoder counter.
// No dependencies; dqec_channel and the top level import this package.
package dqec_pkg;

    // Item codes carried in the func field.
    localparam logic FUNC_SAMPLE   = 1'b0;
    localparam logic FUNC_SUBTRACT = 1'b1;

    // Standard x4 decode table: sixteen 2-bit steps, entry h at bits [2h+1:2h].
    localparam logic [31:0] STEP_TABLE_RESET = 32'd876855580;

    // Pin bits that belong to each motor.
    localparam logic [3:0] PINS_MASK_A = 4'h5;
    localparam logic [3:0] PINS_MASK_B = 4'hA;

    // Control bundle that the top level hands to each channel.
    typedef struct packed {
        logic       load;     // a word is accepted this cycle
        logic       func;     // FUNC_SAMPLE or FUNC_SUBTRACT
        logic       changed;  // one of this motor's pins moved
        logic [1:0] pair;     // current pin pair, pin1 high, pin2 low
    } dqec_chan_ctl_t;

    // Sign-extended step for a 4-bit history index.
    function automatic logic [31:0] step_lookup(input logic [31:0] tbl, input logic [3:0] idx);
        logic [1:0] e;
        e = tbl[{idx, 1'b0} +: 2];
        return {{30{e[1]}}, e};
    endfunction

endpackage

[rtl/dqec_in_if.sv]
// Input channel interface: valid/ready handshake with one sample or subtract word.
// Depends on nothing.
interface dqec_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [3:0]         pins;
    logic signed [31:0] offset_a;
    logic signed [31:0] offset_b;

    modport source (output valid, func, pins, offset_a, offset_b, input ready);
    modport sink   (input valid, func, pins, offset_a, offset_b, output ready);
endinterface

[rtl/dqec_out_if.sv]
// Output channel interface: valid/ready handshake with one word of both counts.
// Depends on nothing.
interface dqec_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] count_a;
    logic signed [31:0] count_b;

    modport source (output valid, count_a, count_b, input ready);
    modport sink   (input valid, count_a, count_b, output ready);
endinterface

[rtl/dqec_channel.sv]
// One motor channel: transition history, step lookup and wrapping position count.
// Depends on dqec_pkg.
module dqec_channel
    import dqec_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  dqec_chan_ctl_t  ctl,
    input  logic [31:0]     offset,
    input  logic [31:0]     step_table,
    output logic [31:0]     position
);

    logic [3:0]  history_reg;
    logic [3:0]  history_next;
    logic [31:0] position_reg;
    logic [31:0] position_next;
    logic [3:0]  hist_shift;
    logic [31:0] step;

    // Shift the new pair into the history and look up its step.
    assign hist_shift = {history_reg[1:0], ctl.pair};
    assign step       = step_lookup(step_table, hist_shift);

    // Next state: subtract an offset, or advance on a pin change.
    always_comb
    begin
        history_next  = history_reg;
        position_next = position_reg;
        if (ctl.load)
        begin
            if (ctl.func == FUNC_SUBTRACT)
            begin
                position_next = position_reg - offset;
            end
            else if (ctl.changed)
            begin
                history_next  = hist_shift;
                position_next = position_reg + step;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg  <= '0;
            position_reg <= '0;
        end
        else
        begin
            history_reg  <= history_next;
            position_reg <= position_next;
        end
    end

    assign position = position_reg;

endmodule

[rtl/dual_quadrature_encoder_counter_top.sv]
// Dual quadrature encoder counter. Each input word is either a pin sample, which advances
// the motor A and motor B counts by steps from the programmable x4 decode table when their
// pins move, or a subtract command that removes offsets from both counts. Every word yields
// one output word with both 32-bit wrapping counts, in the cycle after it is accepted. The
// block takes one word per clock while the sink keeps up; the table lookup and 32-bit add
// are combinational and feed the count registers, which also serve as the output register.
// Input ready drops only while a finished result is held and the sink is not taking it.
// Write step_table only while idle. Depends on dqec_pkg, dqec_in_if, dqec_out_if, dqec_channel.
module dual_quadrature_encoder_counter_top
    import dqec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    dqec_in_if.sink      sample_in,
    dqec_out_if.source   count_out
);

    logic [31:0]    step_table_reg;
    logic [3:0]     last_pins_reg;
    logic [3:0]     last_pins_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           accept;
    logic [3:0]     changed;
    dqec_chan_ctl_t ctl_a;
    dqec_chan_ctl_t ctl_b;
    logic [31:0]    position_a;
    logic [31:0]    position_b;

    // Take a new word whenever the output slot is empty or being emptied.
    assign sample_in.ready = !out_valid_reg || count_out.ready;
    assign accept          = sample_in.valid && sample_in.ready;
    assign changed         = sample_in.pins ^ last_pins_reg;

    // Per-motor control.
    always_comb
    begin
        ctl_a.load    = accept;
        ctl_a.func    = sample_in.func;
        ctl_a.changed = |(changed & PINS_MASK_A);
        ctl_a.pair    = {sample_in.pins[0], sample_in.pins[2]};
        ctl_b.load    = accept;
        ctl_b.func    = sample_in.func;
        ctl_b.changed = |(changed & PINS_MASK_B);
        ctl_b.pair    = {sample_in.pins[1], sample_in.pins[3]};
    end

    dqec_channel u_chan_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_a),
        .offset     (sample_in.offset_a),
        .step_table (step_table_reg),
        .position   (position_a)
    );

    dqec_channel u_chan_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_b),
        .offset     (sample_in.offset_b),
        .step_table (step_table_reg),
        .position   (position_b)
    );

    // Pin memory moves on every sample word; output valid follows accepts.
    always_comb
    begin
        last_pins_next = last_pins_reg;
        if (accept && sample_in.func == FUNC_SAMPLE)
        begin
            last_pins_next = sample_in.pins;
        end
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (count_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_table_reg <= STEP_TABLE_RESET;
            last_pins_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_table_reg <= cfg_wdata;
            end
            last_pins_reg <= last_pins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The count registers are the output word.
    assign count_out.valid   = out_valid_reg;
    assign count_out.count_a = position_a;
    assign count_out.count_b = position_b;

    // Every accepted word produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word did not raise output valid");

    // A held result that is not taken blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !count_out.ready) |-> !sample_in.ready)
        else $error("input ready while output stalled");

    // Subtract words leave the pin memory alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample_in.func == FUNC_SUBTRACT) |=> $stable(last_pins_reg))
        else $error("subtract word changed last pins");

    // Counts move only when a word is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(position_a) && $stable(position_b)))
        else $error("count changed without an accepted word");

endmodule

[tb/dual_quadrature_encoder_counter_top_tb.sv]
// Self-checking testbench for the dual quadrature encoder counter: a directed table of sample
// and subtract words, then random encoder motion under several step tables and handshake loads.
// Depends on dqec_pkg, dqec_in_if, dqec_out_if and the dual_quadrature_encoder_counter_top RTL.
`timescale 1ns / 100ps

module dual_quadrature_encoder_counter_top_tb;
    import dqec_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 11;
    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 275;
    localparam int DRAIN_CYCLES    = 4;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_NS      = 2_000_000;
    localparam int DIR_ROWS        = 25;

    // One input word and one word of both counts.
    typedef struct {
        logic        func;
        logic [3:0]  pins;
        logic [31:0] off_a;
        logic [31:0] off_b;
    } in_word_t;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
    } counts_t;

    // Directed row: the word, and optionally the counts expected after it.
    typedef struct packed {
        logic        func;
        logic [3:0]  pins;
        logic [31:0] off_a;
        logic [31:0] off_b;
        logic        typed;
        logic [31:0] want_a;
        logic [31:0] want_b;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // Fresh out of reset, nothing moved.
        '{FUNC_SAMPLE,   4'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
        // Subtracting the offset extremes, wrapping both ways; pins are ignored.
        '{FUNC_SUBTRACT, 4'hF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 32'h8000_0001},
        '{FUNC_SUBTRACT, 4'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0001, 32'h0000_0001},
        '{FUNC_SUBTRACT, 4'hA, 32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h0000_0000},
        '{FUNC_SUBTRACT, 4'h5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 32'h0000_0001},
        '{FUNC_SUBTRACT, 4'h0, 32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h0000_0000},
        // Sample equal to the last one: offsets ignored, no count moves.
        '{FUNC_SAMPLE,   4'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
        // Motor A forward then backward through the Gray cycle.
        '{FUNC_SAMPLE,   4'h1, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'h5, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'h4, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'h4, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'h5, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'h1, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        // Motor B forward.
        '{FUNC_SAMPLE,   4'h2, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'hA, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'h8, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        // Both motors together, including jumps where both pins of a motor flip.
        '{FUNC_SAMPLE,   4'h3, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'hF, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'hC, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        // Subtract leaves the pin history alone, so the repeated sample changes nothing.
        '{FUNC_SUBTRACT, 4'h3, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        '{FUNC_SAMPLE,   4'hC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    dqec_in_if  sample_if ();
    dqec_out_if count_if ();

    dual_quadrature_encoder_counter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample_in (sample_if),
        .count_out (count_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state: a private copy of the counter and its decode table.
    logic [31:0] table_model;
    logic [3:0]  prev_pins;
    logic [3:0]  hist_a;
    logic [3:0]  hist_b;
    logic [31:0] pos_a;
    logic [31:0] pos_b;

    counts_t     count_q [$];
    counts_t     want_now;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          fail_count;
    int          words_sent;
    int          words_checked;

    // Sign-extended step for one history index.
    function automatic logic [31:0] step_of(input logic [3:0] idx);
        logic signed [1:0]  entry;
        logic signed [31:0] wide;
        entry = table_model[int'(idx) * 2 +: 2];
        wide  = entry;
        return wide;
    endfunction

    // Apply one accepted word to the model and return both counts after it.
    function automatic void advance_counts(input in_word_t w, output counts_t res);
        logic [3:0] moved;
        if (w.func == FUNC_SUBTRACT)
        begin
            pos_a = pos_a - w.off_a;
            pos_b = pos_b - w.off_b;
        end
        else
        begin
            moved     = w.pins ^ prev_pins;
            prev_pins = w.pins;
            if ((moved & PINS_MASK_A) != 4'h0)
            begin
                hist_a = {hist_a[1:0], w.pins[0], w.pins[2]};
                pos_a  = pos_a + step_of(hist_a);
            end
            if ((moved & PINS_MASK_B) != 4'h0)
            begin
                hist_b = {hist_b[1:0], w.pins[1], w.pins[3]};
                pos_b  = pos_b + step_of(hist_b);
            end
        end
        res.a = pos_a;
        res.b = pos_b;
    endfunction

    // Move one pin pair along the Gray cycle: most often a step forward, sometimes a step back,
    // sometimes no move, now and then a skip of two positions.
    function automatic logic [1:0] walk_pair(input logic [1:0] pair);
        logic [1:0] g;
        int         r;
        g = {pair[1], pair[1] ^ pair[0]};
        r = $urandom_range(0, 9);
        if (r < 4)
            g = g + 2'd1;
        else if (r < 7)
            g = g - 2'd1;
        else if (r == 9)
            g = g + 2'd2;
        return g ^ (g >> 1);
    endfunction

    // Offsets lean on the extremes so the wrap is hit often.
    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'($urandom_range(0, 64)) - 32'd32;
            default: return $urandom;
        endcase
    endfunction

    function automatic void report_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Present a word and hold it until accepted; the model runs at the accepting edge.
    task automatic push_word(input in_word_t w, input logic typed, input counts_t want);
        counts_t got;
        sample_if.valid    <= 1'b1;
        sample_if.func     <= w.func;
        sample_if.pins     <= w.pins;
        sample_if.offset_a <= w.off_a;
        sample_if.offset_b <= w.off_b;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        advance_counts(w, got);
        count_q.push_back(typed ? want : got);
        words_sent++;
    endtask

    // Let every outstanding word drain, then write the step table.
    task automatic write_step_table(input logic [31:0] value);
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (count_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        table_model = value;
        cfg_we <= 1'b0;
    endtask

    // Count sink: check each accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            count_if.ready <= 1'b0;
        end
        else
        begin
            if (count_if.valid && count_if.ready)
            begin
                if (count_q.size() == 0)
                begin
                    report_fail($sformatf("unexpected count word a=%h b=%h",
                                          count_if.count_a, count_if.count_b));
                end
                else
                begin
                    want_now = count_q.pop_front();
                    if (count_if.count_a !== want_now.a || count_if.count_b !== want_now.b)
                        report_fail($sformatf("count word %0d: expected a=%h b=%h, got a=%h b=%h",
                                              words_checked, want_now.a, want_now.b,
                                              count_if.count_a, count_if.count_b));
                end
                words_checked++;
            end
            count_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        in_word_t    w;
        counts_t     want;
        logic [1:0]  pa;
        logic [1:0]  pb;
        logic [31:0] tbl;
        int          r;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= 32'h0;
        sample_if.valid    <= 1'b0;
        sample_if.func     <= FUNC_SAMPLE;
        sample_if.pins     <= 4'h0;
        sample_if.offset_a <= 32'h0;
        sample_if.offset_b <= 32'h0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fail_count     = 0;
        words_sent     = 0;
        words_checked  = 0;
        table_model    = STEP_TABLE_RESET;
        prev_pins      = 4'h0;
        hist_a         = 4'h0;
        hist_b         = 4'h0;
        pos_a          = 32'h0;
        pos_b          = 32'h0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at full rate with the reset decode table.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            w.func  = DIR_TAB[i].func;
            w.pins  = DIR_TAB[i].pins;
            w.off_a = DIR_TAB[i].off_a;
            w.off_b = DIR_TAB[i].off_b;
            want.a  = DIR_TAB[i].want_a;
            want.b  = DIR_TAB[i].want_b;
            push_word(w, DIR_TAB[i].typed, want);
        end

        // Random phases: each one writes a step table and sets a handshake load.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: tbl = 32'hFFFF_FFFF;
                1: tbl = 32'hAAAA_AAAA;
                2: tbl = 32'h5555_5555;
                3: tbl = 32'h0000_0000;
                4: tbl = $urandom;
                default: tbl = STEP_TABLE_RESET;
            endcase
            write_step_table(tbl);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase

            for (int i = 0; i < WORDS_PER_PHASE; i++)
            begin
                r       = $urandom_range(0, 99);
                w.off_a = pick_offset();
                w.off_b = pick_offset();
                if (r < 10)
                begin
                    w.func = FUNC_SUBTRACT;
                    w.pins = 4'($urandom);
                end
                else if (r < 15)
                begin
                    w.func = FUNC_SAMPLE;
                    w.pins = 4'($urandom);
                end
                else
                begin
                    // Plausible encoder motion from where the pins stand now.
                    w.func = FUNC_SAMPLE;
                    pa     = walk_pair({prev_pins[0], prev_pins[2]});
                    pb     = walk_pair({prev_pins[1], prev_pins[3]});
                    w.pins = {pb[0], pa[0], pb[1], pa[1]};
                end
                push_word(w, 1'b0, want);

                // Sender gap of random length.
                if ($urandom_range(0, 99) < send_idle_pct)
                begin
                    sample_if.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while ($urandom_range(0, 99) < send_idle_pct);
                end
            end
        end

        // Drain everything still in flight.
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (count_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input words and %0d checked count words,",
                 words_sent, words_checked);
        $display("over %0d step table settings with full rate, sender gaps and sink stalls.",
                 PHASES + 1);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #TIMEOUT_NS;
        $display("Timeout with %0d count words still expected.", count_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/dqec_pkg.sv
rtl/dqec_in_if.sv
rtl/dqec_out_if.sv
rtl/dqec_channel.sv
rtl/dual_quadrature_encoder_counter_top.sv
tb/dual_quadrature_encoder_counter_top_tb.sv
